// ===== hdl/assert_macros.svh =====
// Assertion helpers, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hdl/brs_pkg.sv =====
`timescale 1ns / 1ps
package brs_pkg;
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_ORG_X  = 3'd3;
    localparam logic [2:0] REG_ORG_Y  = 3'd4;
    localparam logic [2:0] REG_TPU_X  = 3'd5;
    localparam logic [2:0] REG_TPU_Y  = 3'd6;

    localparam logic [1:0] FMT_ELEV  = 2'd0;
    localparam logic [1:0] FMT_COLOR = 2'd1;
    localparam logic [1:0] FMT_GRAY  = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic [1:0]         fmt;
        logic [8:0]         width;
        logic [8:0]         height;
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic [31:0]        tpu_x;
        logic [31:0]        tpu_y;
    } t_cfg;
endpackage

// ===== hdl/brs_ram.sv =====
`timescale 1ns / 1ps
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/brs_locate.sv =====
`timescale 1ns / 1ps
// Coordinate to texel index and fraction, three register stages.
// Stage A: d = coord - origin. Stage B/C: 33x32 product split in two halves.
module brs_locate (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_coord,
    input  logic signed [31:0]  i_org,
    input  logic [31:0]         i_tpu,
    output logic signed [48:0]  o_idx,
    output logic [15:0]         o_frac
);
    logic signed [32:0] r_d;
    logic [31:0]        r_tpu_a;
    logic               r_neg_b;
    logic [63:0]        r_lo_b;
    logic [63:0]        r_hi_b;
    logic signed [65:0] r_t_c;

    logic [32:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic signed [65:0] n_t;

    assign mag = r_d[32] ? 33'(-r_d) : 33'(r_d);

    always_comb begin
        prod = r_lo_b + r_hi_b;
        q    = {16'd0, prod[63:16]};
        if (r_neg_b) begin
            n_t = -$signed({2'b00, q + 64'(prod[15:0] != 16'd0)});
        end else begin
            n_t = $signed({2'b00, q});
        end
        n_t = n_t - 66'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= 33'(i_coord) - 33'(i_org);
            r_tpu_a <= i_tpu;
            r_neg_b <= r_d[32];
            r_lo_b  <= 64'(mag[15:0] * r_tpu_a);
            r_hi_b  <= 64'(mag[32:16] * r_tpu_a) << 16;
            r_t_c   <= n_t;
        end
    end

    assign o_idx  = r_t_c[64:16];
    assign o_frac = r_t_c[15:0];
endmodule

// ===== hdl/brs_blend.sv =====
`timescale 1ns / 1ps
// Weights, products and sum over three stages.
module brs_blend (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [1:0]  i_fmt,
    input  logic [15:0] i_fx,
    input  logic [15:0] i_fy,
    input  logic [31:0] i_p0,
    input  logic [31:0] i_p1,
    input  logic [31:0] i_p2,
    input  logic [31:0] i_p3,
    output logic [31:0] o_value
);
    localparam logic [1:0] FMT_ELEV_C  = brs_pkg::FMT_ELEV;
    localparam logic [1:0] FMT_COLOR_C = brs_pkg::FMT_COLOR;
    localparam logic [1:0] FMT_GRAY_C  = brs_pkg::FMT_GRAY;

    logic [1:0]  r_fmt_a, r_fmt_b;
    logic [32:0] r_w_a [4];
    logic [31:0] r_p_a [4];
    logic signed [65:0] r_es_b [4];
    logic [40:0] r_cb_b [4][4];
    logic [31:0] r_val;

    logic [16:0] gx, gy, hx, hy;
    logic signed [67:0] esum;
    logic [42:0] csum [4];
    logic [31:0] n_val;

    always_comb begin
        gx = 17'd65536 - 17'(i_fx);
        gy = 17'd65536 - 17'(i_fy);
        hx = 17'(i_fx);
        hy = 17'(i_fy);
    end

    always_comb begin
        esum = 68'(r_es_b[0]) + 68'(r_es_b[1]) + 68'(r_es_b[2]) + 68'(r_es_b[3])
             + 68'sd2147483648;
        for (int b = 0; b < 4; b++) begin
            csum[b] = 43'(r_cb_b[0][b]) + 43'(r_cb_b[1][b]) + 43'(r_cb_b[2][b])
                    + 43'(r_cb_b[3][b]) + 43'd2147483648;
        end
        unique case (r_fmt_b)
            FMT_ELEV_C:  n_val = esum[63:32];
            FMT_COLOR_C: n_val = {csum[3][39:32], csum[2][39:32],
                                  csum[1][39:32], csum[0][39:32]};
            FMT_GRAY_C:  n_val = {24'd0, csum[0][39:32]};
            default:     n_val = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fmt_a  <= i_fmt;
            r_w_a[0] <= 33'(gx * gy);
            r_w_a[1] <= 33'(hx * gy);
            r_w_a[2] <= 33'(gx * hy);
            r_w_a[3] <= 33'(hx * hy);
            r_p_a[0] <= i_p0;
            r_p_a[1] <= i_p1;
            r_p_a[2] <= i_p2;
            r_p_a[3] <= i_p3;
            r_fmt_b  <= r_fmt_a;
            for (int k = 0; k < 4; k++) begin
                r_es_b[k] <= 66'($signed(r_p_a[k]) * $signed({1'b0, r_w_a[k]}));
                for (int b = 0; b < 4; b++) begin
                    r_cb_b[k][b] <= 41'(r_p_a[k][8*b +: 8] * r_w_a[k]);
                end
            end
            r_val <= n_val;
        end
    end

    assign o_value = r_val;
endmodule

// ===== hdl/bilinear_raster_sampler.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Contents
// s_axis  | in  | tvalid/tready        | tdata {coord_y,coord_x,write_value,row,col}, tuser func
// m_axis  | out | tvalid/tready        | tdata sample_value
// cfg     | in  | i_cfg_valid/o_cfg_ready | index 0..6, data 32 bits
//
// One word per cycle unless the output stalls; pipe of 3 locate stages, 1 bank address, 1 RAM read,
// 1 fetch select, 3 blend stages. The texel store is banked four ways by row and
// column parity so the four taps read in the same cycle. Writes trail by three stages so
// they land in stream order against the reads. The whole pipe advances only when the
// output register is free or taken; tready follows that. Reset clears valids and
// sets config to its defaults; the store is not cleared. Config is always ready.
`include "assert_macros.svh"
module bilinear_raster_sampler #(
    parameter int MAX_COLS = brs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = brs_pkg::MAX_ROWS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] write_col, [15:8] write_row, [47:16] write_value,
    // [79:48] coord_x, [111:80] coord_y
    input  logic [111:0] s_axis_tdata,
    // [0] func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] sample_value
    output logic [31:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int CB = $clog2(MAX_COLS);
    localparam int RB = $clog2(MAX_ROWS);
    localparam int HC = (MAX_COLS + 1) / 2;
    localparam int HR = (MAX_ROWS + 1) / 2;
    localparam int HCB = (HC > 1) ? $clog2(HC) : 1;
    localparam int HRB = (HR > 1) ? $clog2(HR) : 1;
    localparam int BD = (1 << HCB) * (1 << HRB);
    localparam int BA = HCB + HRB;
    localparam int LAT = 9;

    brs_pkg::t_cfg r_cfg;
    logic en;
    logic [LAT-2:0] r_vld;
    logic r_out_vld;

    // Config writes.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt    <= brs_pkg::FMT_ELEV;
            r_cfg.width  <= 9'd1;
            r_cfg.height <= 9'd1;
            r_cfg.org_x  <= '0;
            r_cfg.org_y  <= '0;
            r_cfg.tpu_x  <= 32'd65536;
            r_cfg.tpu_y  <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brs_pkg::REG_FORMAT: r_cfg.fmt    <= i_cfg_data[1:0];
                brs_pkg::REG_WIDTH:  r_cfg.width  <= i_cfg_data[8:0];
                brs_pkg::REG_HEIGHT: r_cfg.height <= i_cfg_data[8:0];
                brs_pkg::REG_ORG_X:  r_cfg.org_x  <= i_cfg_data;
                brs_pkg::REG_ORG_Y:  r_cfg.org_y  <= i_cfg_data;
                brs_pkg::REG_TPU_X:  r_cfg.tpu_x  <= i_cfg_data;
                brs_pkg::REG_TPU_Y:  r_cfg.tpu_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipe advances when the output stage is empty or draining.
    assign en = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    logic acc_s, acc_w;
    assign acc_s = s_axis_tvalid && en && (s_axis_tuser == brs_pkg::FUNC_SAMPLE);
    assign acc_w = s_axis_tvalid && en && (s_axis_tuser == brs_pkg::FUNC_WRITE);

    // r_vld[i] marks a sample in stage i+1; the output register is stage 9.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-3:0], acc_s};
            end
            if (en) begin
                r_out_vld <= r_vld[LAT-2];
            end
        end
    end

    // Writes go to the bank chosen by parity, three stages after acceptance.
    logic [7:0] wcol, wrow;
    logic       w_in;
    assign wcol = s_axis_tdata[7:0];
    assign wrow = s_axis_tdata[15:8];
    assign w_in = (32'(wcol) < MAX_COLS) && (32'(wrow) < MAX_ROWS);
    logic [BA-1:0] waddr;
    assign waddr = {HRB'(wrow >> 1), HCB'(wcol >> 1)};

    logic [2:0]    r_wv;
    logic [1:0]    r_wbk [3];
    logic [BA-1:0] r_wad [3];
    logic [31:0]   r_wdt [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= '0;
        end else if (en) begin
            r_wv <= {r_wv[1:0], acc_w && w_in};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wbk[0] <= {wrow[0], wcol[0]};
            r_wad[0] <= waddr;
            r_wdt[0] <= s_axis_tdata[47:16];
            for (int k = 1; k < 3; k++) begin
                r_wbk[k] <= r_wbk[k-1];
                r_wad[k] <= r_wad[k-1];
                r_wdt[k] <= r_wdt[k-1];
            end
        end
    end

    // Locate.
    logic signed [48:0] ix, iy;
    logic [15:0] fx, fy;
    brs_locate u_loc_x (.i_clk, .i_en(en), .i_coord(s_axis_tdata[79:48]),
        .i_org(r_cfg.org_x), .i_tpu(r_cfg.tpu_x), .o_idx(ix), .o_frac(fx));
    brs_locate u_loc_y (.i_clk, .i_en(en), .i_coord(s_axis_tdata[111:80]),
        .i_org(r_cfg.org_y), .i_tpu(r_cfg.tpu_y), .o_idx(iy), .o_frac(fy));

    // Tap bounds and bank addresses.
    logic [8:0] wlim, hlim;
    assign wlim = (32'(r_cfg.width) < MAX_COLS) ? r_cfg.width : 9'(MAX_COLS);
    assign hlim = (32'(r_cfg.height) < MAX_ROWS) ? r_cfg.height : 9'(MAX_ROWS);

    logic signed [49:0] c0, c1, rr0, rr1;
    assign c0 = 50'(ix);
    assign c1 = 50'(ix) + 50'sd1;
    assign rr0 = 50'(iy);
    assign rr1 = 50'(iy) + 50'sd1;
    logic okc0, okc1, okr0, okr1;
    assign okc0 = !c0[49] && (c0 < 50'(wlim));
    assign okc1 = !c1[49] && (c1 < 50'(wlim));
    assign okr0 = !rr0[49] && (rr0 < 50'(hlim));
    assign okr1 = !rr1[49] && (rr1 < 50'(hlim));

    // Even/odd column and row of the 2x2 footprint.
    logic [CB:0] ce, co;
    logic [RB:0] re, ro;
    logic okce, okco, okre, okro;
    logic cswap, rswap;
    always_comb begin
        cswap = c0[0];
        rswap = rr0[0];
        ce   = cswap ? (CB+1)'(c1) : (CB+1)'(c0);
        co   = cswap ? (CB+1)'(c0) : (CB+1)'(c1);
        okce = cswap ? okc1 : okc0;
        okco = cswap ? okc0 : okc1;
        re   = rswap ? (RB+1)'(rr1) : (RB+1)'(rr0);
        ro   = rswap ? (RB+1)'(rr0) : (RB+1)'(rr1);
        okre = rswap ? okr1 : okr0;
        okro = rswap ? okr0 : okr1;
    end

    logic [BA-1:0] r_ad [4];
    logic [3:0]    r_ok_a, r_ok_b;
    logic          r_cs_a, r_rs_a, r_cs_b, r_rs_b;
    logic [15:0]   r_fx_a, r_fy_a, r_fx_b, r_fy_b, r_fx_c, r_fy_c;
    logic [1:0]    r_fmt_a, r_fmt_b, r_fmt_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            // bank k: bit0 col odd, bit1 row odd
            r_ad[0] <= {HRB'(re >> 1), HCB'(ce >> 1)};
            r_ad[1] <= {HRB'(re >> 1), HCB'(co >> 1)};
            r_ad[2] <= {HRB'(ro >> 1), HCB'(ce >> 1)};
            r_ad[3] <= {HRB'(ro >> 1), HCB'(co >> 1)};
            r_ok_a  <= {okro && okco, okro && okce, okre && okco, okre && okce};
            r_cs_a  <= cswap;
            r_rs_a  <= rswap;
            r_fx_a  <= fx;
            r_fy_a  <= fy;
            r_fmt_a <= r_cfg.fmt;
            r_ok_b  <= r_ok_a;
            r_cs_b  <= r_cs_a;
            r_rs_b  <= r_rs_a;
            r_fx_b  <= r_fx_a;
            r_fy_b  <= r_fy_a;
            r_fmt_b <= r_fmt_a;
            r_fx_c  <= r_fx_b;
            r_fy_c  <= r_fy_b;
            r_fmt_c <= r_fmt_b;
        end
    end

    logic [31:0] bank_q [4];
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic we;
        assign we = en && r_wv[2] && (r_wbk[2] == 2'(k));
        brs_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
            .i_clk, .i_we(we), .i_waddr(r_wad[2]), .i_wdata(r_wdt[2]),
            .i_re(en), .i_raddr(r_ad[k]), .o_rdata(bank_q[k]));
    end

    // Put banks back into tap order and mask out-of-raster taps.
    logic [31:0] q_m [4];
    logic [31:0] r_p [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            q_m[k] = r_ok_b[k] ? bank_q[k] : 32'd0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= q_m[{k[1] ^ r_rs_b, k[0] ^ r_cs_b}];
            end
        end
    end

    brs_blend u_blend (.i_clk, .i_en(en), .i_fmt(r_fmt_c), .i_fx(r_fx_c), .i_fy(r_fy_c),
        .i_p0(r_p[0]), .i_p1(r_p[1]), .i_p2(r_p[2]), .i_p3(r_p[3]),
        .o_value(m_axis_tdata));

    assign m_axis_tvalid = r_out_vld;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready),
        "input ready does not follow output stage")
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, en && r_vld[LAT-2], m_axis_tvalid,
        "finished sample lost")
endmodule

// ===== sim/bilinear_raster_sampler_test.sv =====
`timescale 1ns / 1ps
module bilinear_raster_sampler_test;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 14;  // pipe is 9 deep, plus margin

    // Golden raster and the queue of blended words still owed by the block.
    class raster_scoreboard;
        bit [31:0]   texels [65536];
        bit          written [65536];
        bit [1:0]    fmt;
        bit [8:0]    width;
        bit [8:0]    height;
        longint      org_x;
        longint      org_y;
        longint unsigned tpu_x;
        longint unsigned tpu_y;
        bit [31:0]   owed [$];
        int          errors;

        function void set_reg(bit [2:0] idx, bit [31:0] v);
            case (idx)
                brs_pkg::REG_FORMAT: fmt = v[1:0];
                brs_pkg::REG_WIDTH:  width = v[8:0];
                brs_pkg::REG_HEIGHT: height = v[8:0];
                brs_pkg::REG_ORG_X:  org_x = longint'(signed'(v));
                brs_pkg::REG_ORG_Y:  org_y = longint'(signed'(v));
                brs_pkg::REG_TPU_X:  tpu_x = v;
                brs_pkg::REG_TPU_Y:  tpu_y = v;
                default: ;
            endcase
        endfunction

        function void reset_regs();
            fmt = brs_pkg::FMT_ELEV; width = 1; height = 1;
            org_x = 0; org_y = 0; tpu_x = 65536; tpu_y = 65536;
        endfunction

        // World coordinate to texel index (floor) and 16-bit fraction, half-texel shifted.
        function void locate(longint coord, longint org, longint unsigned scale,
                             output longint idx, output int unsigned frac);
            longint d;
            longint unsigned mag, m, q;
            longint t;
            d = coord - org;
            mag = (d < 0) ? longint'(-d) : d;
            m = mag * scale;
            q = m >> 16;
            if (d < 0) begin
                if (m[15:0] != 0) q++;
                t = -longint'(q);
            end else begin
                t = longint'(q);
            end
            t -= 32768;
            frac = t[15:0];
            idx = t >>> 16;
        endfunction

        function bit [31:0] tap(longint c, longint r);
            longint w, h;
            w = (width < 256) ? width : 256;
            h = (height < 256) ? height : 256;
            if (c < 0 || r < 0 || c >= w || r >= h) return 32'd0;
            return texels[r * 256 + c];
        endfunction

        function bit [31:0] blend(bit [31:0] p [4], longint wt [4]);
            longint acc_s;
            longint unsigned acc_u, u;
            bit [31:0] r;
            r = 32'd0;
            if (fmt == brs_pkg::FMT_ELEV) begin
                acc_s = 0;
                for (int k = 0; k < 4; k++)
                    acc_s += longint'(signed'(p[k])) * wt[k];
                u = longint'(acc_s) + 64'h8000_0000_8000_0000;
                r = u[63:32] ^ 32'h8000_0000;
            end else if (fmt == brs_pkg::FMT_COLOR || fmt == brs_pkg::FMT_GRAY) begin
                for (int b = 0; b < 4; b++) begin
                    acc_u = 64'h8000_0000;
                    for (int k = 0; k < 4; k++)
                        acc_u += longint'(p[k][b*8 +: 8]) * wt[k];
                    if (fmt == brs_pkg::FMT_COLOR || b == 0) r[b*8 +: 8] = acc_u[39:32];
                end
            end
            return r;
        endfunction

        function void note_word(bit func, bit [7:0] col, bit [7:0] row, bit [31:0] val,
                                bit [31:0] cx, bit [31:0] cy);
            longint px, py, fx1, fy1;
            int unsigned fx, fy;
            bit [31:0] p [4];
            longint wt [4];
            if (func == brs_pkg::FUNC_WRITE) begin
                texels[int'(row) * 256 + col] = val;
                written[int'(row) * 256 + col] = 1'b1;
                return;
            end
            locate(longint'(signed'(cx)), org_x, tpu_x, px, fx);
            locate(longint'(signed'(cy)), org_y, tpu_y, py, fy);
            p[0] = tap(px, py);     p[1] = tap(px + 1, py);
            p[2] = tap(px, py + 1); p[3] = tap(px + 1, py + 1);
            fx1 = 65536 - fx; fy1 = 65536 - fy;
            wt[0] = fx1 * fy1;             wt[1] = longint'(fx) * fy1;
            wt[2] = fx1 * longint'(fy);    wt[3] = longint'(fx) * longint'(fy);
            owed.push_back(blend(p, wt));
        endfunction

        function void check(bit [31:0] got);
            bit [31:0] want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %08h", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("sample_value: expected %08h got %08h", want, got);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    raster_scoreboard sb;
    int  cycles = 0;
    int  words_sent;
    bit  long_hold;

    bilinear_raster_sampler u_top (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("bilinear_raster_sampler_test NOT OK");
            $finish;
        end
    end

    // Gaps come in bursts: every third run of 64 words is sent back to back.
    function automatic int draw_gap();
        if ((words_sent / 64) % 3 == 2) return 0;
        return $urandom_range(0, 7);
    endfunction

    // Result side: random per-word stall, one long hold-off on request.
    initial begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            w = draw_gap();
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);

    task automatic cfg_write(bit [2:0] idx, bit [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(bit func, bit [7:0] col, bit [7:0] row, bit [31:0] val,
                             bit [31:0] cx, bit [31:0] cy);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {cy, cx, val, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(func, col, row, val, cx, cy);
        words_sent++;
    endtask

    task automatic sample_at(bit [31:0] cx, bit [31:0] cy);
        send_word(brs_pkg::FUNC_SAMPLE, 8'($urandom), 8'($urandom), $urandom, cx, cy);
    endtask

    // Idle the stream and let all owed words come home before touching config.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // World coordinate near texel space, so most samples land on the raster.
    function automatic bit [31:0] aim(longint org, longint unsigned scale, int span);
        longint t;
        if (scale == 0 || $urandom_range(0, 3) == 0) return $urandom;
        t = longint'($urandom_range(0, (span + 4) * 65536)) - 2 * 65536;
        return 32'(org + (t * 65536) / longint'(scale));
    endfunction

    task automatic run_phase(bit [31:0] fmt, bit [31:0] w, bit [31:0] h, bit [31:0] ox,
                             bit [31:0] oy, bit [31:0] sx, bit [31:0] sy, int n);
        int ww, hh;
        drain();
        cfg_write(brs_pkg::REG_FORMAT, fmt);
        cfg_write(brs_pkg::REG_WIDTH, w);
        cfg_write(brs_pkg::REG_HEIGHT, h);
        cfg_write(brs_pkg::REG_ORG_X, ox);
        cfg_write(brs_pkg::REG_ORG_Y, oy);
        cfg_write(brs_pkg::REG_TPU_X, sx);
        cfg_write(brs_pkg::REG_TPU_Y, sy);
        // Make sure no tap in use can hit a texel never written.
        ww = (w[8:0] < 256) ? w[8:0] : 256;
        hh = (h[8:0] < 256) ? h[8:0] : 256;
        for (int r = 0; r < hh; r++)
            for (int c = 0; c < ww; c++)
                if (!sb.written[r * 256 + c])
                    send_word(brs_pkg::FUNC_WRITE, 8'(c), 8'(r), $urandom, 0, 0);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && fmt == brs_pkg::FMT_COLOR) long_hold = 1'b1;
            if ($urandom_range(0, 9) < 3)
                send_word(brs_pkg::FUNC_WRITE, 8'($urandom), 8'($urandom), $urandom,
                          $urandom, $urandom);
            else
                sample_at(aim(sb.org_x, sb.tpu_x, ww), aim(sb.org_y, sb.tpu_y, hh));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        words_sent = 0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, 1x1 raster of elevation.
        send_word(brs_pkg::FUNC_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 0);
        sample_at(32'h0000_8000, 32'h0000_8000);     // dead centre of the texel
        sample_at(0, 0);                              // half-way to the empty border
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(32'h8000_0000, 32'h8000_0000);
        send_word(brs_pkg::FUNC_WRITE, 0, 0, 32'h8000_0000, 0, 0);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_C000, 32'h0000_4000);
        send_word(brs_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0);  // kept, outside
        drain();
        cfg_write(3'd7, 32'hFFFF_FFFF);                                     // unused index
        send_word(brs_pkg::FUNC_WRITE, 0, 0, 32'hFF00_FF01, 0, 0);
        drain();
        cfg_write(brs_pkg::REG_FORMAT, brs_pkg::FMT_COLOR);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_7FFF, 32'h0000_8001);
        sample_at(32'h0000_0000, 32'h0001_0000);
        drain();
        cfg_write(brs_pkg::REG_FORMAT, brs_pkg::FMT_GRAY);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_4000, 32'h0000_8000);

        // Random phases over the register space, extremes included.
        run_phase(brs_pkg::FMT_ELEV, 4, 4, 0, 0, 32'h0001_0000, 32'h0001_0000, 40);
        run_phase(brs_pkg::FMT_COLOR, 256, 1, 32'hFFF0_0000, 32'h0000_0000,
                  32'h0004_0000, 32'h0002_0000, 40);
        run_phase(brs_pkg::FMT_GRAY, 1, 256, $urandom, $urandom,
                  32'h0000_8000, 32'h0008_0000, 40);
        run_phase(brs_pkg::FMT_ELEV, 8, 5, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0001, 32'hFFFF_FFFF, 40);
        run_phase(brs_pkg::FMT_COLOR, 6, 7, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'h0000_0000, 40);
        run_phase(2'd3, 3, 3, $urandom, $urandom, $urandom, $urandom, 40);
        run_phase(brs_pkg::FMT_ELEV, 0, 5, 0, 0, 32'h0001_0000, 32'h0001_0000, 40);
        run_phase(brs_pkg::FMT_GRAY, 9'h1FF, 1, $urandom, 0,
                  32'h0003_0000, 32'h0001_0000, 40);
        run_phase(brs_pkg::FMT_ELEV, 1, 1, $urandom, $urandom, $urandom, $urandom, 40);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("bilinear_raster_sampler_test OK");
        end else begin
            $display("bilinear_raster_sampler_test NOT OK");
        end
        $finish;
    end
endmodule

// ===== bilinear_raster_sampler.f =====
+incdir+hdl
hdl/brs_pkg.sv
hdl/brs_ram.sv
hdl/brs_locate.sv
hdl/brs_blend.sv
hdl/bilinear_raster_sampler.sv
sim/bilinear_raster_sampler_test.sv
